### rtl/core/spbs_pkg.sv
// Shared types, constants and register codes for the power-button sequencer.
// No dependencies; the top level, spbs_csr and spbs_chan_alu import this package.
`timescale 1ns / 1ps
`default_nettype none

package spbs_pkg;

   // Number of relay channels held in the channel memories.
   localparam int CHANNELS = 8;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MASK_W   = 8;
   localparam int PAD_W    = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
   localparam int CMP_W    = (CH_IDX_W > 4) ? CH_IDX_W + 1 : 5;
   localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNELS - 1);

   // Item opcodes.
   localparam logic [2:0] OPC_TICK    = 3'd0;
   localparam logic [2:0] OPC_ON      = 3'd1;
   localparam logic [2:0] OPC_OFF     = 3'd2;
   localparam logic [2:0] OPC_RESTART = 3'd3;
   localparam logic [2:0] OPC_PING    = 3'd4;

   // Timed operation codes kept per channel in the phase memory.
   typedef logic [2:0] chan_op_type;
   localparam chan_op_type CHOP_IDLE  = 3'd0;
   localparam chan_op_type CHOP_ON    = 3'd1;
   localparam chan_op_type CHOP_OFF   = 3'd2;
   localparam chan_op_type CHOP_PRESS = 3'd3;
   localparam chan_op_type CHOP_GAP   = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [2:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [2:0] CSR_TURN_ON       = 3'd1;
   localparam logic [2:0] CSR_TURN_OFF      = 3'd2;
   localparam logic [2:0] CSR_RESTART_GAP   = 3'd3;
   localparam logic [2:0] CSR_PING_TIMEOUT  = 3'd4;

   localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd8;
   localparam logic [15:0] RST_TURN_ON       = 16'd500;
   localparam logic [15:0] RST_TURN_OFF      = 16'd5000;
   localparam logic [15:0] RST_RESTART_GAP   = 16'd2000;
   localparam logic [23:0] RST_PING_TIMEOUT  = 24'd60000;

   typedef struct packed {
      logic [2:0] opcode;
      logic [2:0] server_index;
      logic [7:0] button_mask;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] relay_mask;
      logic [7:0] alive_mask;
      logic [7:0] busy_mask;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  channel_count;
      logic [15:0] turn_on_pulse_ms;
      logic [15:0] turn_off_pulse_ms;
      logic [15:0] restart_gap_ms;
      logic [23:0] ping_timeout_ms;
   } cfg_type;

   // One entry of the phase memory.
   typedef struct packed {
      chan_op_type op;
      logic [31:0] start;
   } phase_entry_type;

   localparam int PHASE_W = $bits(phase_entry_type);

   // What the channel unit sees of one channel.
   typedef struct packed {
      logic [2:0]      opcode;
      logic            target;
      logic            in_use;
      logic            held;
      logic            forcing;
      logic            relay;
      phase_entry_type phase;
      logic [31:0]     ping_time;
      logic [31:0]     now;
   } chan_in_type;

   // What the channel unit hands back for write-back.
   typedef struct packed {
      logic            relay;
      logic            forcing;
      logic            phase_we;
      phase_entry_type phase;
      logic            ping_we;
      logic            alive;
      logic            accepted;
   } chan_out_type;

endpackage

`default_nettype wire

### rtl/core/server_power_button_sequencer.sv
// Top level of the power-button relay sequencer: sequencer, channel memories.
// Depends on spbs_pkg, spbs_ram, spbs_csr and spbs_chan_alu.
//
// Usage:
//   req_valid/req_stall/req_data carry one item a beat: a millisecond tick with
//   the manual button levels, a turn-on, turn-off or restart command, or a ping.
//   rsp_valid/rsp_stall/rsp_data return one result beat per item: accepted flag
//   and the relay, alive and busy masks after the item.
//   csr_valid/csr_ready/csr_index/csr_data write the configuration registers;
//   writes are always ready and must only be issued while the block is idle.
//   Each item walks all CHANNELS entries of the phase and ping memories, one
//   channel read and written back per cycle; a new item is taken only once
//   the previous item's result has been loaded into the output register.
//   The result sits in an output register; a stalled result does not block
//   the next item, only the next result's hand-over.
//   Reset clears all control state, the configuration to its defaults and the
//   per-entry valid bits; entries never written read as zero, so no clearing
//   pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module server_power_button_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire spbs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output spbs_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_data
);
   import spbs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_FIN  = 3'b100
   } seq_state_type;

   cfg_type         cfg;
   seq_state_type   state_ff, state_in;
   logic            req_take;
   logic            rsp_free;

   logic [31:0]         now_ff, now_in;
   logic [MASK_W-1:0]   prev_ff, prev_in;
   logic [2:0]          opcode_ff, opcode_in;
   logic [2:0]          index_ff, index_in;
   logic [CHANNELS-1:0] held_ff, held_in;
   logic [PAD_W-1:0]    held_pad;

   logic                rd_active_ff, rd_active_in;
   logic [CH_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic                proc_valid_ff, proc_valid_in;
   logic [CH_IDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic                phase_ok_ff, phase_ok_in;
   logic                ping_ok_ff, ping_ok_in;

   logic [CHANNELS-1:0] relay_ff, relay_in;
   logic [CHANNELS-1:0] forcing_ff, forcing_in;
   logic [CHANNELS-1:0] busy_ff, busy_in;
   logic [CHANNELS-1:0] alive_ff, alive_in;
   logic [CHANNELS-1:0] phase_valid_ff, phase_valid_in;
   logic [CHANNELS-1:0] ping_valid_ff, ping_valid_in;
   logic                acc_ff, acc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [PHASE_W-1:0]  phase_rd;
   logic [31:0]         ping_rd;
   chan_in_type         ch_in;
   chan_out_type        ch_out;
   logic                wb_phase;
   logic                wb_ping;
   logic [PAD_W-1:0]    relay_pad, alive_pad, busy_pad;

   spbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Phase memory: timed operation code and phase start time per channel.
   spbs_ram #(.WIDTH(PHASE_W), .DEPTH(CHANNELS)) u_phase_ram (
      .clock   (clock),
      .wr_en   (wb_phase),
      .wr_addr (proc_idx_ff),
      .wr_data (ch_out.phase),
      .rd_en   (rd_active_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (phase_rd)
   );

   // Ping memory: time of the last ping per channel.
   spbs_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_ping_ram (
      .clock   (clock),
      .wr_en   (wb_ping),
      .wr_addr (proc_idx_ff),
      .wr_data (now_ff),
      .rd_en   (rd_active_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (ping_rd)
   );

   // Handshakes: one item in flight, result parked in the output register.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign held_pad  = PAD_W'(req_data.button_mask & prev_ff);

   // Channel unit inputs; never-written entries read as their reset value.
   always_comb begin
      ch_in.opcode    = opcode_ff;
      ch_in.target    = (CMP_W'(proc_idx_ff) == CMP_W'(index_ff));
      ch_in.in_use    = (CMP_W'(proc_idx_ff) < CMP_W'(cfg.channel_count));
      ch_in.held      = held_ff[proc_idx_ff];
      ch_in.forcing   = forcing_ff[proc_idx_ff];
      ch_in.relay     = relay_ff[proc_idx_ff];
      ch_in.phase     = phase_ok_ff ? phase_entry_type'(phase_rd)
                                    : phase_entry_type'({CHOP_IDLE, 32'b0});
      ch_in.ping_time = ping_ok_ff ? ping_rd : 32'b0;
      ch_in.now       = now_ff;
   end

   spbs_chan_alu u_chan_alu (
      .ch_in  (ch_in),
      .cfg    (cfg),
      .ch_out (ch_out)
   );

   assign wb_phase = proc_valid_ff && ch_out.phase_we;
   assign wb_ping  = proc_valid_ff && ch_out.ping_we;

   // Sequencer: take an item, walk the channels, hand over the result.
   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      prev_in        = prev_ff;
      opcode_in      = opcode_ff;
      index_in       = index_ff;
      held_in        = held_ff;
      rd_active_in   = rd_active_ff;
      rd_idx_in      = rd_idx_ff;
      proc_valid_in  = 1'b0;
      proc_idx_in    = proc_idx_ff;
      phase_ok_in    = phase_ok_ff;
      ping_ok_in     = ping_ok_ff;
      relay_in       = relay_ff;
      forcing_in     = forcing_ff;
      busy_in        = busy_ff;
      alive_in       = alive_ff;
      phase_valid_in = phase_valid_ff;
      ping_valid_in  = ping_valid_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in     = ST_WALK;
               opcode_in    = req_data.opcode;
               index_in     = req_data.server_index;
               held_in      = held_pad[CHANNELS-1:0];
               acc_in       = (req_data.opcode == OPC_TICK);
               alive_in     = '0;
               rd_active_in = 1'b1;
               rd_idx_in    = '0;
               if (req_data.opcode == OPC_TICK) begin
                  now_in  = now_ff + 32'd1;
                  prev_in = req_data.button_mask;
               end
            end
         end
         ST_WALK: begin
            // Read stage: issue the next channel, remember its valid bits.
            if (rd_active_ff) begin
               proc_valid_in = 1'b1;
               proc_idx_in   = rd_idx_ff;
               phase_ok_in   = phase_valid_ff[rd_idx_ff];
               ping_ok_in    = ping_valid_ff[rd_idx_ff];
               if (rd_idx_ff == CH_LAST) begin
                  rd_active_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + CH_IDX_W'(1);
               end
            end
            // Update stage: write the channel back.
            if (proc_valid_ff) begin
               relay_in[proc_idx_ff]   = ch_out.relay;
               forcing_in[proc_idx_ff] = ch_out.forcing;
               alive_in[proc_idx_ff]   = ch_out.alive;
               acc_in                  = acc_ff | ch_out.accepted;
               if (ch_out.phase_we) begin
                  busy_in[proc_idx_ff]        = (ch_out.phase.op != CHOP_IDLE);
                  phase_valid_in[proc_idx_ff] = 1'b1;
               end
               if (ch_out.ping_we) begin
                  ping_valid_in[proc_idx_ff] = 1'b1;
               end
               if (proc_idx_ff == CH_LAST) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in              = ST_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_in.accepted       = acc_ff;
               rsp_in.relay_mask     = relay_pad[MASK_W-1:0];
               rsp_in.alive_mask     = alive_pad[MASK_W-1:0];
               rsp_in.busy_mask      = busy_pad[MASK_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign relay_pad = PAD_W'(relay_ff);
   assign alive_pad = PAD_W'(alive_ff);
   assign busy_pad  = PAD_W'(busy_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         now_ff         <= '0;
         prev_ff        <= '0;
         rd_active_ff   <= 1'b0;
         rd_idx_ff      <= '0;
         proc_valid_ff  <= 1'b0;
         proc_idx_ff    <= '0;
         relay_ff       <= '0;
         forcing_ff     <= '0;
         busy_ff        <= '0;
         alive_ff       <= '0;
         phase_valid_ff <= '0;
         ping_valid_ff  <= '0;
         acc_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         now_ff         <= now_in;
         prev_ff        <= prev_in;
         rd_active_ff   <= rd_active_in;
         rd_idx_ff      <= rd_idx_in;
         proc_valid_ff  <= proc_valid_in;
         proc_idx_ff    <= proc_idx_in;
         relay_ff       <= relay_in;
         forcing_ff     <= forcing_in;
         busy_ff        <= busy_in;
         alive_ff       <= alive_in;
         phase_valid_ff <= phase_valid_in;
         ping_valid_ff  <= ping_valid_in;
         acc_ff         <= acc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      index_ff    <= index_in;
      held_ff     <= held_in;
      phase_ok_ff <= phase_ok_in;
      ping_ok_ff  <= ping_ok_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A pressed relay always belongs to a timed operation or a held button.
   a_relay_owned: assert property (@(posedge clock) disable iff (reset)
      (relay_ff & ~(busy_ff | forcing_ff)) == '0)
      else $error("relay pressed with no operation or manual hold");

   // A new result is only loaded from the hand-over state.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result loaded outside hand-over");

   // Memory write-back happens only for a channel in the update stage.
   a_wb_in_walk: assert property (@(posedge clock) disable iff (reset)
      (wb_phase || wb_ping) |-> (state_ff == ST_WALK))
      else $error("channel memory written outside the walk");

   // The last channel's update ends the walk.
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (proc_valid_ff && (proc_idx_ff == CH_LAST)) |=> (state_ff == ST_FIN))
      else $error("walk did not end after the last channel");

endmodule

`default_nettype wire

### rtl/core/spbs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/spbs_csr.sv
// Configuration register bank of the power-button sequencer.
// Depends on spbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spbs_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [23:0]      csr_data,
   output spbs_pkg::cfg_type     cfg
);
   import spbs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: cfg_in.channel_count     = csr_data[3:0];
            CSR_TURN_ON:       cfg_in.turn_on_pulse_ms  = csr_data[15:0];
            CSR_TURN_OFF:      cfg_in.turn_off_pulse_ms = csr_data[15:0];
            CSR_RESTART_GAP:   cfg_in.restart_gap_ms    = csr_data[15:0];
            CSR_PING_TIMEOUT:  cfg_in.ping_timeout_ms   = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count     <= RST_CHANNEL_COUNT;
         cfg_ff.turn_on_pulse_ms  <= RST_TURN_ON;
         cfg_ff.turn_off_pulse_ms <= RST_TURN_OFF;
         cfg_ff.restart_gap_ms    <= RST_RESTART_GAP;
         cfg_ff.ping_timeout_ms   <= RST_PING_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/spbs_chan_alu.sv
// Per-channel update logic: manual button, timed phases, commands and pings.
// Depends on spbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spbs_chan_alu (
   input  wire spbs_pkg::chan_in_type ch_in,
   input  wire spbs_pkg::cfg_type     cfg,
   output spbs_pkg::chan_out_type     ch_out
);
   import spbs_pkg::*;

   logic [31:0] elapsed;
   logic [31:0] ping_age;
   logic [31:0] ping_eff;
   logic [31:0] timeout_ext;
   logic        alive_pre;
   logic        relay_tmp;
   logic        expired_on;
   logic        expired_off;
   logic        expired_gap;
   logic        cmd_ok;

   // Wrapping ages of the phase and of the last ping.
   assign elapsed     = ch_in.now - ch_in.phase.start;
   assign timeout_ext = {8'b0, cfg.ping_timeout_ms};
   assign ping_age    = ch_in.now - ch_in.ping_time;
   assign alive_pre   = ping_age < timeout_ext;

   assign expired_on  = elapsed > {16'b0, cfg.turn_on_pulse_ms};
   assign expired_off = elapsed > {16'b0, cfg.turn_off_pulse_ms};
   assign expired_gap = elapsed > {16'b0, cfg.restart_gap_ms};

   // A command needs an idle channel; turn-on wants it dead, the others alive.
   assign cmd_ok = ch_in.target && ch_in.in_use && (ch_in.phase.op == CHOP_IDLE) &&
                   ((ch_in.opcode == OPC_ON) ? !alive_pre : alive_pre);

   always_comb begin
      ch_out.relay    = ch_in.relay;
      ch_out.forcing  = ch_in.forcing;
      ch_out.phase_we = 1'b0;
      ch_out.phase    = ch_in.phase;
      ch_out.ping_we  = 1'b0;
      ch_out.accepted = 1'b0;
      relay_tmp       = ch_in.relay;
      case (ch_in.opcode)
         OPC_TICK: begin
            if (ch_in.in_use) begin
               if (ch_in.held) begin
                  ch_out.relay   = 1'b1;
                  ch_out.forcing = 1'b1;
               end else begin
                  // Release a forced press, then run the timed phase.
                  relay_tmp      = ch_in.forcing ? 1'b0 : ch_in.relay;
                  ch_out.forcing = 1'b0;
                  case (ch_in.phase.op)
                     CHOP_ON: begin
                        if (expired_on) begin
                           relay_tmp       = 1'b0;
                           ch_out.phase.op = CHOP_IDLE;
                           ch_out.phase_we = 1'b1;
                        end
                     end
                     CHOP_OFF: begin
                        if (expired_off) begin
                           relay_tmp       = 1'b0;
                           ch_out.phase.op = CHOP_IDLE;
                           ch_out.phase_we = 1'b1;
                        end
                     end
                     CHOP_PRESS: begin
                        if (expired_off) begin
                           relay_tmp          = 1'b0;
                           ch_out.phase.op    = CHOP_GAP;
                           ch_out.phase.start = ch_in.now;
                           ch_out.phase_we    = 1'b1;
                        end
                     end
                     CHOP_GAP: begin
                        if (expired_gap) begin
                           relay_tmp          = 1'b1;
                           ch_out.phase.op    = CHOP_ON;
                           ch_out.phase.start = ch_in.now;
                           ch_out.phase_we    = 1'b1;
                        end
                     end
                     default: begin
                        relay_tmp = relay_tmp;
                     end
                  endcase
                  ch_out.relay = relay_tmp;
               end
            end
         end
         OPC_ON, OPC_OFF, OPC_RESTART: begin
            if (cmd_ok) begin
               ch_out.phase.op    = (ch_in.opcode == OPC_RESTART) ? CHOP_PRESS :
                                    ((ch_in.opcode == OPC_ON) ? CHOP_ON : CHOP_OFF);
               ch_out.phase.start = ch_in.now;
               ch_out.phase_we    = 1'b1;
               ch_out.relay       = 1'b1;
               ch_out.accepted    = 1'b1;
            end
         end
         OPC_PING: begin
            if (ch_in.target && ch_in.in_use) begin
               ch_out.ping_we  = 1'b1;
               ch_out.accepted = 1'b1;
            end
         end
         default: begin
            ch_out.accepted = 1'b0;
         end
      endcase
   end

   // Liveness after this item, with a fresh ping counting as age zero.
   assign ping_eff     = ch_out.ping_we ? ch_in.now : ch_in.ping_time;
   assign ch_out.alive = ch_in.in_use && ((ch_in.now - ping_eff) < timeout_ext);

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the power-button relay sequencer.
// Depends on spbs_pkg and server_power_button_sequencer; a scoreboard class predicts every beat.
`timescale 1ns / 1ps

module tb;

   import spbs_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 30;
   localparam int SETTLE_CYCLES = 12;

   // Opcodes the block does not define.
   localparam logic [2:0] OPC_SPARE_A = 3'd5;
   localparam logic [2:0] OPC_SPARE_B = 3'd6;
   localparam logic [2:0] OPC_SPARE_C = 3'd7;

   // Relay state tracker: its own copy of configuration and channel state.
   class relay_tracker;
      logic [3:0]  channel_count;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
      logic [15:0] gap_ms;
      logic [23:0] timeout_ms;
      logic [31:0] now_ms;
      logic [31:0] phase_start [CHANNELS];
      logic [31:0] ping_time [CHANNELS];
      chan_op_type op_state [CHANNELS];
      bit          relay [CHANNELS];
      bit          forcing [CHANNELS];
      logic [7:0]  buttons_prev;
      rsp_type     expected_status [$];
      int          errors;

      function new();
         channel_count = RST_CHANNEL_COUNT;
         on_ms = RST_TURN_ON;
         off_ms = RST_TURN_OFF;
         gap_ms = RST_RESTART_GAP;
         timeout_ms = RST_PING_TIMEOUT;
         now_ms = '0;
         buttons_prev = '0;
         errors = 0;
         for (int i = 0; i < CHANNELS; i++) begin
            phase_start[i] = '0;
            ping_time[i] = '0;
            op_state[i] = CHOP_IDLE;
            relay[i] = 1'b0;
            forcing[i] = 1'b0;
         end
      endfunction

      function void set_register(logic [2:0] index, logic [23:0] value);
         case (index)
            CSR_CHANNEL_COUNT: channel_count = value[3:0];
            CSR_TURN_ON:       on_ms = value[15:0];
            CSR_TURN_OFF:      off_ms = value[15:0];
            CSR_RESTART_GAP:   gap_ms = value[15:0];
            CSR_PING_TIMEOUT:  timeout_ms = value;
            default: ;
         endcase
      endfunction

      function int in_use();
         return (channel_count > CHANNELS) ? CHANNELS : int'(channel_count);
      endfunction

      function bit is_alive(int i);
         logic [31:0] age;
         age = now_ms - ping_time[i];
         return age < 32'(timeout_ms);
      endfunction

      // Ends the current phase once its elapsed time exceeds its length.
      function void advance(int i);
         logic [31:0] elapsed;
         elapsed = now_ms - phase_start[i];
         case (op_state[i])
            CHOP_ON:
               if (elapsed > 32'(on_ms)) begin
                  relay[i] = 1'b0;
                  op_state[i] = CHOP_IDLE;
               end
            CHOP_OFF:
               if (elapsed > 32'(off_ms)) begin
                  relay[i] = 1'b0;
                  op_state[i] = CHOP_IDLE;
               end
            CHOP_PRESS:
               if (elapsed > 32'(off_ms)) begin
                  relay[i] = 1'b0;
                  op_state[i] = CHOP_GAP;
                  phase_start[i] = now_ms;
               end
            CHOP_GAP:
               if (elapsed > 32'(gap_ms)) begin
                  relay[i] = 1'b1;
                  op_state[i] = CHOP_ON;
                  phase_start[i] = now_ms;
               end
            default: ;
         endcase
      endfunction

      // A tick walks every channel in use: manual button first, then the timer.
      function void tick(logic [7:0] buttons);
         int n;
         bit held;
         n = in_use();
         now_ms = now_ms + 32'd1;
         for (int i = 0; i < n; i++) begin
            held = (i < MASK_W) && buttons[i] && buttons_prev[i];
            if (held) begin
               relay[i] = 1'b1;
               forcing[i] = 1'b1;
            end else begin
               if (forcing[i]) begin
                  relay[i] = 1'b0;
                  forcing[i] = 1'b0;
               end
               advance(i);
            end
         end
         buttons_prev = buttons;
      endfunction

      function bit command(logic [2:0] op, int idx);
         bit alive;
         if (idx >= in_use()) return 1'b0;
         if (op_state[idx] != CHOP_IDLE) return 1'b0;
         alive = is_alive(idx);
         if ((op == OPC_ON) ? alive : !alive) return 1'b0;
         if (op == OPC_RESTART) op_state[idx] = CHOP_PRESS;
         else if (op == OPC_ON) op_state[idx] = CHOP_ON;
         else op_state[idx] = CHOP_OFF;
         relay[idx] = 1'b1;
         phase_start[idx] = now_ms;
         return 1'b1;
      endfunction

      // Notes an accepted request beat and queues the status it must produce.
      function void take_request(req_type item);
         rsp_type status;
         int idx;
         idx = int'(item.server_index);
         status = '0;
         case (item.opcode)
            OPC_TICK: begin
               tick(item.button_mask);
               status.accepted = 1'b1;
            end
            OPC_ON, OPC_OFF, OPC_RESTART:
               status.accepted = command(item.opcode, idx);
            OPC_PING:
               if (idx < in_use()) begin
                  ping_time[idx] = now_ms;
                  status.accepted = 1'b1;
               end
            default: ;
         endcase
         for (int i = 0; i < CHANNELS && i < MASK_W; i++) begin
            status.relay_mask[i] = relay[i];
            status.busy_mask[i] = (op_state[i] != CHOP_IDLE);
            status.alive_mask[i] = (i < in_use()) && is_alive(i);
         end
         expected_status.push_back(status);
      endfunction

      // Compares one result beat with the oldest queued status.
      function void check_status(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            $error("result beat with no request pending: %h", got);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %b, actual %b", want.accepted, got.accepted);
            errors++;
         end
         if (got.relay_mask !== want.relay_mask) begin
            $error("relay_mask: expected %h, actual %h", want.relay_mask, got.relay_mask);
            errors++;
         end
         if (got.alive_mask !== want.alive_mask) begin
            $error("alive_mask: expected %h, actual %h", want.alive_mask, got.alive_mask);
            errors++;
         end
         if (got.busy_mask !== want.busy_mask) begin
            $error("busy_mask: expected %h, actual %h", want.busy_mask, got.busy_mask);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   relay_tracker tracker = new();
   int           cycle_count = 0;
   bit           quiet = 1'b0;
   logic [7:0]   button_level = '0;

   server_power_button_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Gap lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_item(logic [2:0] op, logic [2:0] idx, logic [7:0] mask);
      req_type item;
      item.opcode = op;
      item.server_index = idx;
      item.button_mask = mask;
      return item;
   endfunction

   // Buttons are held over several ticks so that manual presses take effect.
   function automatic req_type random_item();
      int r;
      logic [2:0] op;
      logic [7:0] mask;
      r = $urandom_range(0, 99);
      if (r < 45) op = OPC_TICK;
      else if (r < 55) op = OPC_ON;
      else if (r < 65) op = OPC_OFF;
      else if (r < 75) op = OPC_RESTART;
      else if (r < 93) op = OPC_PING;
      else op = 3'($urandom_range(OPC_SPARE_A, OPC_SPARE_C));
      if ($urandom_range(0, 5) == 0) begin
         if ($urandom_range(0, 3) == 0) button_level = '0;
         else button_level = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
      end
      mask = (op == OPC_TICK) ? button_level : 8'($urandom_range(0, 255));
      return make_item(op, 3'($urandom_range(0, 7)), mask);
   endfunction

   // Drives one request beat and waits until the block takes it.
   task automatic send_request(req_type item);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      tracker.take_request(item);
   endtask

   task automatic send_random(int count);
      for (int k = 0; k < count; k++) begin
         if (k % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
         send_request(random_item());
      end
      quiet = 1'b0;
   endtask

   // Lets every pending result come back before the block is reconfigured.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(index, value);
   endtask

   task automatic apply_settings(logic [3:0] count, logic [15:0] on_ms, logic [15:0] off_ms,
                                 logic [15:0] gap_ms, logic [23:0] timeout_ms);
      settle();
      write_register(CSR_CHANNEL_COUNT, 24'(count));
      write_register(CSR_TURN_ON, 24'(on_ms));
      write_register(CSR_TURN_OFF, 24'(off_ms));
      write_register(CSR_RESTART_GAP, 24'(gap_ms));
      write_register(CSR_PING_TIMEOUT, timeout_ms);
      csr_valid <= 1'b0;
   endtask

   // Result side: random stalls, with long stall-free stretches now and then.
   initial begin
      int stall_len;
      int free_len;
      rsp_stall = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) free_len = $urandom_range(50, 200);
         else free_len = pick_gap() + 1;
         rsp_stall <= 1'b0;
         repeat (free_len) @(posedge clock);
      end
   end

   // Every result beat taken is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_status(rsp_data);
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CHANNEL_COUNT;
      csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: all channels alive, long pulses.
      send_request(make_item(OPC_TICK, 3'd0, 8'h00));
      send_request(make_item(OPC_ON, 3'd0, 8'h00));
      send_request(make_item(OPC_OFF, 3'd0, 8'hFF));
      send_request(make_item(OPC_OFF, 3'd0, 8'h00));
      send_request(make_item(OPC_RESTART, 3'd1, 8'h00));
      send_request(make_item(OPC_RESTART, 3'd7, 8'h00));
      send_request(make_item(OPC_PING, 3'd7, 8'h00));
      send_request(make_item(OPC_PING, 3'd3, 8'hFF));
      send_request(make_item(OPC_TICK, 3'd7, 8'hFF));
      send_request(make_item(OPC_TICK, 3'd0, 8'hFF));
      send_request(make_item(OPC_OFF, 3'd2, 8'h00));
      send_request(make_item(OPC_TICK, 3'd0, 8'hAA));
      send_request(make_item(OPC_TICK, 3'd0, 8'h00));
      send_request(make_item(OPC_SPARE_A, 3'd0, 8'h00));
      send_request(make_item(OPC_SPARE_B, 3'd7, 8'hFF));
      send_request(make_item(OPC_SPARE_C, 3'd4, 8'h5A));
      send_request(make_item(OPC_TICK, 3'd0, 8'h55));

      // No channel in use: every command and ping is refused.
      apply_settings(4'd0, 16'd0, 16'd0, 16'd0, 24'd0);
      send_request(make_item(OPC_ON, 3'd0, 8'h00));
      send_request(make_item(OPC_OFF, 3'd0, 8'h00));
      send_request(make_item(OPC_RESTART, 3'd0, 8'h00));
      send_request(make_item(OPC_PING, 3'd0, 8'h00));
      send_request(make_item(OPC_TICK, 3'd0, 8'hFF));
      send_random(20);

      // Short timings over all eight channels.
      apply_settings(4'd8, 16'd2, 16'd3, 16'd1, 24'd6);
      send_random(150);

      // One channel, zero-length phases, never alive.
      apply_settings(4'd1, 16'd0, 16'd0, 16'd0, 24'd0);
      send_request(make_item(OPC_PING, 3'd1, 8'h00));
      send_request(make_item(OPC_ON, 3'd0, 8'h00));
      send_request(make_item(OPC_TICK, 3'd0, 8'h00));
      send_request(make_item(OPC_TICK, 3'd0, 8'h00));
      send_random(50);

      // Count above the channel total, longest timings.
      apply_settings(4'd15, 16'd65535, 16'd65535, 16'd65535, 24'd16777215);
      send_random(40);

      // Partial channel count with random short timings.
      apply_settings(4'd5, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 5)),
                     16'($urandom_range(0, 3)), 24'($urandom_range(1, 20)));
      send_random(160);

      // Drain and decide.
      req_valid <= 1'b0;
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_status.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
